// ===== rtl/core/hciadv_pkg.sv =====
// ----------------------------------------------------------------------------
// hciadv_pkg
// Types and constants for the hci advertising report parser: packet offsets,
// event selectors, result kinds and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package hciadv_pkg;

  // byte offsets within one event packet
  localparam logic [8:0] OFF_LENGTH     = 9'd2;
  localparam logic [8:0] OFF_EVT_LO     = 9'd3;
  localparam logic [8:0] OFF_EVT_HI     = 9'd4;
  localparam logic [8:0] OFF_ID_FIRST   = 9'd6;
  localparam logic [8:0] OFF_ID_LAST    = 9'd9;
  localparam logic [8:0] OFF_ADDR_FIRST = 9'd12;
  localparam logic [8:0] OFF_ADDR_LAST  = 9'd17;
  localparam logic [8:0] OFF_RSSI       = 9'd22;
  localparam logic [8:0] HEADER_BYTES   = 9'd3;

  localparam logic [15:0] EVT_SCANNER       = 16'h0613;
  localparam logic [31:0] EVT_ID_ADV_REPORT = 32'h0040_0000;

  // rssi of a total result: zero byte minus 256
  localparam logic signed [8:0] RSSI_NONE = 9'sh100;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_TOTAL  = 1'b1;

  // result queue
  localparam int unsigned RES_DEPTH    = 4;
  localparam int unsigned RES_PTR_BITS = 2;
  localparam int unsigned RES_CNT_BITS = 3;

  localparam int unsigned OUT_DATA_BITS = 80;

  typedef struct packed {
    logic              kind;
    logic [47:0]       address;
    logic signed [8:0] rssi_dbm;
    logic [15:0]       device_count;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hci_adv_report_parser.sv =====
// ----------------------------------------------------------------------------
// hci_adv_report_parser
// Splits a received hci uart byte stream into event packets and reports
// advertising devices with their address, rssi and index.
// ----------------------------------------------------------------------------
// usage:
//   s_axis: one received byte per transaction in tdata; tuser marks the first
//   byte of a buffer (packet offset and device count restart), tlast its end.
//   m_axis: result transactions; tuser is the kind (0 report, 1 total count),
//   tlast marks the final result caused by one input byte.
//   throughput: one byte per cycle while s_axis_tready is high; each byte
//   is parsed into a 4-entry result queue. A byte that yields both a report
//   and a total pushes two results, the report first.
//   s_axis_tready is high while the queue has room for two results, so a
//   stalled receiver holds up input once the queue holds more than two.
//   reset: rst (synchronous) clears the parser state, the device count and
//   the result queue; no results are pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_adv_report_parser #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] first_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [47:0] address, [56:48] rssi_dbm,
                                           // [72:57] device_count, [79:73] zero
  output logic             m_axis_tuser,   // [0] kind
  output logic             m_axis_tlast
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // parser state
  logic [8:0]            packet_offset, packet_offset_next;
  logic [7:0]            packet_length, packet_length_next;
  logic [15:0]           event_word, event_word_next;
  logic [31:0]           event_identifier, event_identifier_next;
  logic [47:0]           device_address, device_address_next;
  logic [COUNT_BITS-1:0] report_count, report_count_next;

  // result queue
  hciadv_pkg::result_t                          res_q [hciadv_pkg::RES_DEPTH];
  logic [hciadv_pkg::RES_PTR_BITS-1:0]          wr_ptr, rd_ptr;
  logic [hciadv_pkg::RES_CNT_BITS-1:0]          fill, fill_next;

  logic                  in_acc, out_acc;
  logic [8:0]            off;
  logic [7:0]            len_eff;
  logic [COUNT_BITS-1:0] cnt_base;
  logic                  hit;
  logic [1:0]            push_n;
  logic [1:0]            id_sel;
  logic [2:0]            addr_sel;
  hciadv_pkg::result_t   rep_res, tot_res, res0, res_head;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign off      = s_axis_tuser ? 9'd0 : packet_offset;
  assign cnt_base = s_axis_tuser ? '0 : report_count;
  assign len_eff  = (off == hciadv_pkg::OFF_LENGTH) ? s_axis_tdata : packet_length;
  assign id_sel   = 2'(off - hciadv_pkg::OFF_ID_FIRST);
  assign addr_sel = 3'(off - hciadv_pkg::OFF_ADDR_FIRST);

  assign hit = (off == hciadv_pkg::OFF_RSSI) &&
               (event_word == hciadv_pkg::EVT_SCANNER) &&
               (event_identifier == hciadv_pkg::EVT_ID_ADV_REPORT);

  always_comb begin
    packet_length_next    = packet_length;
    event_word_next       = event_word;
    event_identifier_next = event_identifier;
    device_address_next   = device_address;
    report_count_next     = cnt_base;

    if (off == hciadv_pkg::OFF_LENGTH) begin
      packet_length_next = s_axis_tdata;
    end else if (off == hciadv_pkg::OFF_EVT_LO) begin
      event_word_next[7:0] = s_axis_tdata;
    end else if (off == hciadv_pkg::OFF_EVT_HI) begin
      event_word_next[15:8] = s_axis_tdata;
    end else if (off >= hciadv_pkg::OFF_ID_FIRST && off <= hciadv_pkg::OFF_ID_LAST) begin
      event_identifier_next[8*id_sel +: 8] = s_axis_tdata;
    end else if (off >= hciadv_pkg::OFF_ADDR_FIRST &&
                 off <= hciadv_pkg::OFF_ADDR_LAST) begin
      device_address_next[8*addr_sel +: 8] = s_axis_tdata;
    end else if (hit && cnt_base != COUNT_MAX) begin
      report_count_next = cnt_base + 1'b1;
    end

    // the byte at offset 2+L closes the packet
    if (off >= hciadv_pkg::OFF_LENGTH &&
        off >= 9'(len_eff) + hciadv_pkg::HEADER_BYTES - 9'd1) begin
      packet_offset_next = 9'd0;
    end else begin
      packet_offset_next = off + 9'd1;
    end
  end

  always_comb begin
    rep_res.kind         = hciadv_pkg::KIND_REPORT;
    rep_res.address      = device_address;
    rep_res.rssi_dbm     = {1'b1, s_axis_tdata};
    rep_res.device_count = 16'(cnt_base);
    rep_res.last         = !s_axis_tlast;

    tot_res.kind         = hciadv_pkg::KIND_TOTAL;
    tot_res.address      = '0;
    tot_res.rssi_dbm     = hciadv_pkg::RSSI_NONE;
    tot_res.device_count = 16'(report_count_next);
    tot_res.last         = 1'b1;

    res0   = hit ? rep_res : tot_res;
    push_n = in_acc ? (2'(hit) + 2'(s_axis_tlast)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_offset    <= '0;
      packet_length    <= '0;
      event_word       <= '0;
      event_identifier <= '0;
      device_address   <= '0;
      report_count     <= '0;
    end else if (in_acc) begin
      packet_offset    <= packet_offset_next;
      packet_length    <= packet_length_next;
      event_word       <= event_word_next;
      event_identifier <= event_identifier_next;
      device_address   <= device_address_next;
      report_count     <= report_count_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      res_q[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      res_q[wr_ptr + 1'b1] <= tot_res;
    end
  end

  assign fill_next = fill + hciadv_pkg::RES_CNT_BITS'(push_n)
                     - hciadv_pkg::RES_CNT_BITS'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + hciadv_pkg::RES_PTR_BITS'(push_n);
      rd_ptr <= rd_ptr + hciadv_pkg::RES_PTR_BITS'(out_acc);
      fill   <= fill_next;
    end
  end

  assign res_head      = res_q[rd_ptr];
  assign s_axis_tready = fill <= hciadv_pkg::RES_CNT_BITS'(hciadv_pkg::RES_DEPTH - 2);
  assign m_axis_tvalid = fill != '0;
  assign m_axis_tdata  = {7'd0, res_head.device_count, res_head.rssi_dbm,
                          res_head.address};
  assign m_axis_tuser  = res_head.kind;
  assign m_axis_tlast  = res_head.last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= hciadv_pkg::RES_CNT_BITS'(hciadv_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |=> m_axis_tvalid)
    else $error("buffer end produced no pending result");

  a_total_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == hciadv_pkg::KIND_TOTAL |-> m_axis_tlast)
    else $error("total result without last mark");

  a_first_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser && !hit |=> report_count == '0)
    else $error("device count not restarted at buffer start");
`endif

endmodule

`default_nettype wire

// ===== verif/hciadv_report_checker.sv =====
// ----------------------------------------------------------------------------
// hciadv_report_checker
// Watches both stream channels of the hci advertising report parser, parses
// every accepted byte on its own to work out the reports and totals that
// should follow, and compares each result transaction with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module hciadv_report_checker #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [79:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               error_count,
  output int               pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // parser state as seen from the byte stream
  logic [8:0]            byte_offset;
  logic [7:0]            pkt_len;
  logic [15:0]           evt_word;
  logic [31:0]           evt_id;
  logic [47:0]           dev_addr;
  logic [COUNT_BITS-1:0] dev_count;

  hciadv_pkg::result_t results_due[$];
  int                  err_tally = 0;

  task automatic flag_error(input string msg);
    $display("[%0t] hciadv_report_checker: %s", $realtime, msg);
    err_tally++;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first, input logic fin);
    logic [8:0]          off;
    hciadv_pkg::result_t r;
    if (first) begin
      byte_offset = '0;
      dev_count   = '0;
    end
    off = byte_offset;
    if (off == hciadv_pkg::OFF_LENGTH) begin
      pkt_len = b;
    end else if (off == hciadv_pkg::OFF_EVT_LO) begin
      evt_word[7:0] = b;
    end else if (off == hciadv_pkg::OFF_EVT_HI) begin
      evt_word[15:8] = b;
    end else if (off >= hciadv_pkg::OFF_ID_FIRST && off <= hciadv_pkg::OFF_ID_LAST) begin
      evt_id[int'(off - hciadv_pkg::OFF_ID_FIRST) * 8 +: 8] = b;
    end else if (off >= hciadv_pkg::OFF_ADDR_FIRST &&
                 off <= hciadv_pkg::OFF_ADDR_LAST) begin
      dev_addr[int'(off - hciadv_pkg::OFF_ADDR_FIRST) * 8 +: 8] = b;
    end else if (off == hciadv_pkg::OFF_RSSI && evt_word == hciadv_pkg::EVT_SCANNER &&
                 evt_id == hciadv_pkg::EVT_ID_ADV_REPORT) begin
      r.kind         = hciadv_pkg::KIND_REPORT;
      r.address      = dev_addr;
      r.rssi_dbm     = {1'b1, b};
      r.device_count = 16'(dev_count);
      r.last         = !fin;
      results_due.push_back(r);
      if (dev_count != '1) dev_count++;
    end
    // the byte at offset 2+len closes the packet
    if (off >= hciadv_pkg::OFF_LENGTH &&
        int'(off) >= int'(pkt_len) + int'(hciadv_pkg::HEADER_BYTES) - 1)
      byte_offset = '0;
    else
      byte_offset = off + 9'd1;
    if (fin) begin
      r.kind         = hciadv_pkg::KIND_TOTAL;
      r.address      = '0;
      r.rssi_dbm     = hciadv_pkg::RSSI_NONE;
      r.device_count = 16'(dev_count);
      r.last         = 1'b1;
      results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    hciadv_pkg::result_t got;
    hciadv_pkg::result_t want;
    if (rst) begin
      byte_offset = '0;
      pkt_len     = '0;
      evt_word    = '0;
      evt_id      = '0;
      dev_addr    = '0;
      dev_count   = '0;
      results_due.delete();
    end else begin
      // input first, so a same-cycle result would still find its expectation
      if (s_axis_tvalid && s_axis_tready)
        parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind         = m_axis_tuser;
        got.address      = m_axis_tdata[47:0];
        got.rssi_dbm     = m_axis_tdata[56:48];
        got.device_count = m_axis_tdata[72:57];
        got.last         = m_axis_tlast;
        if (results_due.size() == 0) begin
          flag_error($sformatf("unexpected result kind=%0d count=%0d", got.kind,
                               got.device_count));
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind)
            flag_error($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.address !== want.address)
            flag_error($sformatf("address %h, expected %h", got.address, want.address));
          if (got.rssi_dbm !== want.rssi_dbm)
            flag_error($sformatf("rssi %0d, expected %0d", got.rssi_dbm, want.rssi_dbm));
          if (got.device_count !== want.device_count)
            flag_error($sformatf("device count %0d, expected %0d", got.device_count,
                                 want.device_count));
          if (got.last !== want.last)
            flag_error($sformatf("last %0d, expected %0d", got.last, want.last));
        end
      end
    end
    pending     <= results_due.size();
    error_count <= err_tally;
  end

endmodule

`default_nettype wire

// ===== verif/tb_hci_adv_report_parser.sv =====
// ----------------------------------------------------------------------------
// tb_hci_adv_report_parser
// Feeds buffers of hci event packets (advertising reports, short reports,
// other events and noise, with restarts and early ends) through the parser
// under bursty input and a stalling receiver, and gives the verdict from the
// checker's error count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hci_adv_report_parser;

  timeunit 1ns;
  timeprecision 1ps;

  // narrow counter so the count field is wider than the counter
  localparam int unsigned CNT_BITS    = 8;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_CYCLES = 400;

  typedef enum int {PKT_REPORT, PKT_SHORT, PKT_OTHER, PKT_NOISE} pkt_sel_t;
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int error_count;
  int pending;
  int cycle_count = 0;
  int sent        = 0;
  int burst_left  = 0;

  logic       hold_go   = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_left = 0;
  rx_mode_t   rx_mode   = RX_OPEN;
  int         rx_phase  = 0;
  int         rx_tick   = 0;

  logic [7:0] byte_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hci_adv_report_parser #(
    .COUNT_BITS(CNT_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser (s_axis_tuser),   // [0] first_byte
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [47:0] address, [56:48] rssi_dbm,
                                    // [72:57] device_count, [79:73] zero
    .m_axis_tuser (m_axis_tuser),   // [0] kind
    .m_axis_tlast (m_axis_tlast)
  );

  hciadv_report_checker #(
    .COUNT_BITS(CNT_BITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .error_count  (error_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_hci_adv_report_parser: errors");
      $finish;
    end
  end

  // receiver: one long hold-off once the sender is well underway, otherwise
  // a ready pattern, open, mostly ready, sparse or periodic, drawn at random
  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        rx_phase = $urandom_range(16, 96);
      end
      rx_phase--;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (rx_tick % 4 != 3);
      endcase
    end
  end

  // one transaction on the input side; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] value, input logic first, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= first;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    if (sent == 300) hold_go <= 1'b1;
    @(negedge clk);
  endtask

  task automatic add_packet(input pkt_sel_t sel);
    int          len;
    logic [15:0] word;
    logic [31:0] ident;
    logic [7:0]  b;
    word  = hciadv_pkg::EVT_SCANNER;
    ident = hciadv_pkg::EVT_ID_ADV_REPORT;
    case (sel)
      PKT_REPORT: len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                    : $urandom_range(20, 24);
      PKT_SHORT:  len = $urandom_range(0, 19);
      PKT_OTHER: begin
        // one bit off in the selector
        len = $urandom_range(20, 30);
        if ($urandom_range(0, 1) == 0) word[$urandom_range(0, 15)] ^= 1'b1;
        else ident[$urandom_range(0, 31)] ^= 1'b1;
      end
      default:    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 24);
    endcase
    for (int i = 0; i < len + 3; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 2) b = 8'(len);
      else if (sel != PKT_NOISE && i >= 3 && i <= 4) b = word[(i - 3) * 8 +: 8];
      else if (sel != PKT_NOISE && i >= 6 && i <= 9) b = ident[(i - 6) * 8 +: 8];
      byte_q.push_back(b);
    end
  endtask

  task automatic send_buffer(input int n_pkts, input bit restart, input bit reports_only);
    int       cut;
    int       early_end;
    int       early_start;
    int       pick;
    pkt_sel_t sel;
    byte_q.delete();
    for (int p = 0; p < n_pkts; p++) begin
      pick = $urandom_range(0, 99);
      if (reports_only || pick < 60) sel = PKT_REPORT;
      else if (pick < 72) sel = PKT_SHORT;
      else if (pick < 86) sel = PKT_OTHER;
      else sel = PKT_NOISE;
      add_packet(sel);
    end
    cut         = byte_q.size();
    early_end   = -1;
    early_start = -1;
    if (!reports_only) begin
      // buffer cut mid-packet, a stray end mark, a stray restart
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, byte_q.size());
      if ($urandom_range(0, 9) == 0) early_end = $urandom_range(0, cut - 1);
      if ($urandom_range(0, 19) == 0 && cut > 1) early_start = $urandom_range(1, cut - 1);
    end
    for (int i = 0; i < cut; i++)
      push_byte(byte_q[i], (restart && i == 0) || i == early_start,
                i == cut - 1 || i == early_end);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: a report whose rssi byte also ends the buffer, extreme
    // address bytes and rssi zero, then a lone byte carrying both marks
    byte_q = '{8'h04, 8'h3E, 8'd20, 8'h13, 8'h06, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h00,
               8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE,
               8'h7F, 8'h00, 8'h00};
    for (int i = 0; i < byte_q.size(); i++)
      push_byte(byte_q[i], i == 0, i == byte_q.size() - 1);
    push_byte(8'hFF, 1'b1, 1'b1);

    while (sent < 1000)
      send_buffer($urandom_range(1, 6), $urandom_range(0, 9) != 0, 1'b0);

    // a run of reports back to back in one buffer
    send_buffer(6, 1'b1, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0)
      $display("tb_hci_adv_report_parser: clean");
    else
      $display("tb_hci_adv_report_parser: errors");
    $finish;
  end

endmodule

`default_nettype wire
